@@ sv/ffha_pkg.sv @@
// Package for the first-fit heap allocator.
// Holds the request and result types, the status codes and the sizing constants.
// No dependencies.
`default_nettype none
package ffha_pkg;

  localparam int unsigned MaxGranules     = 65536;
  localparam int unsigned InitialGranules = 4096;
  localparam int unsigned MinGrowGranules = 4096;
  localparam int unsigned PageGranules    = 256;
  localparam logic [63:0] ResetHeapBase   = 64'hffff_ffff_c000_0000;

  localparam logic       ReqAlloc = 1'b0;
  localparam logic       ReqFree  = 1'b1;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNull    = 2'd1;
  localparam logic [1:0] StNoMem   = 2'd2;
  localparam logic [1:0] StBadFree = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [20:0] size_bytes;
    logic [63:0] address;
  } req_t;

  typedef struct packed {
    logic [63:0] address_res;
    logic [1:0]  status;
    logic        grew;
  } res_t;

endpackage
`default_nettype wire

@@ sv/first_fit_heap_allocator.sv @@
// First-fit heap allocator over an implicit block list in a header memory.
// Uses ffha_pkg for the transfer types, status codes and sizing constants.
// Allocate walks the headers, grows the heap if no block fits and writes the
// headers; free walks to its block, merges free neighbours, writes one header.
// The header memory read port, one header per cycle in a walk, sets throughput.
// One request is in flight at a time. Reset restores the initial free block
// at once through an override flag on entry 0; no clearing pass is needed.
`default_nettype none
module first_fit_heap_allocator import ffha_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire req_t        in_req_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output res_t             out_res_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [63:0] cfg_data_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_AWALK = 4'd1;
  localparam logic [3:0] S_GROW  = 4'd2;
  localparam logic [3:0] S_TAKE1 = 4'd3;
  localparam logic [3:0] S_TAKE2 = 4'd4;
  localparam logic [3:0] S_FWALK = 4'd5;
  localparam logic [3:0] S_FNEXT = 4'd6;
  localparam logic [3:0] S_FWR   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [16:0] InitExtent = 17'(InitialGranules);
  localparam logic [15:0] InitSize   = 16'(InitialGranules - 1);
  localparam logic [19:0] MaxExt     = 20'(MaxGranules);
  localparam logic [18:0] PageMask   = ~19'(PageGranules - 1);
  localparam logic [18:0] MinGrow    = 19'(MinGrowGranules);

  logic [16:0] mem [MaxGranules];
  logic [16:0] rdata_q;
  logic        rd0_q, init0_q;
  logic [15:0] raddr, waddr;
  logic [16:0] wdata;
  logic        we;

  logic [3:0]  state_q, state_d;
  logic [63:0] base_q;
  logic [16:0] extent_q, extent_d;
  logic [17:0] g_q, g_d;
  logic [17:0] need_q, need_d;
  logic [16:0] target_q, target_d;
  logic [17:0] last_q, last_d;
  logic [15:0] last_size_q, last_size_d;
  logic        last_free_q, last_free_d;
  logic [17:0] prev_q, prev_d;
  logic [15:0] prev_size_q, prev_size_d;
  logic        prev_free_q, prev_free_d, has_prev_q, has_prev_d;
  logic [15:0] merged_q, merged_d;
  logic [17:0] tg_q, tg_d;
  logic [15:0] tsz_q, tsz_d;
  res_t        res_q, res_d, out_q;
  logic        out_valid_q;

  logic [15:0] d_size;
  logic        d_free;
  logic [17:0] nxt;
  logic [18:0] add_r, add;
  logic        split;
  logic [63:0] off;
  logic        accept;

  assign d_size = (init0_q && rd0_q) ? InitSize : rdata_q[16:1];
  assign d_free = (init0_q && rd0_q) ? 1'b1 : rdata_q[0];
  assign nxt    = g_q + 18'd1 + {2'b0, d_size};
  assign add_r  = ({1'b0, need_q} + 19'(PageGranules)) & PageMask;
  assign add    = (add_r < MinGrow) ? MinGrow : add_r;
  assign split  = {3'b0, tsz_q} >= {1'b0, need_q} + 19'd2;
  assign off    = in_req_i.address - base_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d = state_q;   extent_d = extent_q;  g_d = g_q;   need_d = need_q;
    target_d = target_q; last_d = last_q;      last_size_d = last_size_q;
    last_free_d = last_free_q; prev_d = prev_q; prev_size_d = prev_size_q;
    prev_free_d = prev_free_q; has_prev_d = has_prev_q; merged_d = merged_q;
    tg_d = tg_q; tsz_d = tsz_q; res_d = res_q;
    raddr = g_q[15:0]; waddr = tg_q[15:0]; wdata = '0; we = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '{address_res: 64'd0, status: StOk, grew: 1'b0};
          g_d = '0; has_prev_d = 1'b0; raddr = '0;
          need_d = 18'(({1'b0, in_req_i.size_bytes} + 22'd15) >> 4);
          target_d = off[20:4] - 17'd1;
          if (in_req_i.req_type == ReqAlloc) begin
            if (in_req_i.size_bytes == '0) begin
              res_d.status = StNull; state_d = S_DONE;
            end else begin
              state_d = S_AWALK;
            end
          end else begin
            if (in_req_i.address == '0) begin
              res_d.status = StNull; state_d = S_DONE;
            end else if (off[3:0] != '0 || off[63:4] == '0 ||
                         off[63:4] > {43'd0, extent_q}) begin
              res_d.status = StBadFree; state_d = S_DONE;
            end else begin
              state_d = S_FWALK;
            end
          end
        end
      end
      S_AWALK: begin
        if (d_free && {2'b0, d_size} >= need_q) begin
          tg_d = g_q; tsz_d = d_size; state_d = S_TAKE1;
        end else begin
          last_d = g_q; last_size_d = d_size; last_free_d = d_free;
          if (nxt < {1'b0, extent_q}) begin
            g_d = nxt; raddr = nxt[15:0];
          end else begin
            state_d = S_GROW;
          end
        end
      end
      S_GROW: begin
        if ({3'b0, extent_q} + {1'b0, add} > MaxExt) begin
          res_d.status = StNoMem; state_d = S_DONE;
        end else begin
          if (last_free_q) begin
            tg_d = last_q; tsz_d = last_size_q + add[15:0];
          end else begin
            tg_d = {1'b0, extent_q}; tsz_d = add[15:0] - 16'd1;
          end
          extent_d = extent_q + add[16:0];
          res_d.grew = 1'b1;
          state_d = S_TAKE1;
        end
      end
      S_TAKE1: begin
        if (split) begin
          we = 1'b1;
          waddr = 16'(tg_q + 18'd1 + need_q);
          wdata = {tsz_q - need_q[15:0] - 16'd1, 1'b1};
        end
        state_d = S_TAKE2;
      end
      S_TAKE2: begin
        we = 1'b1;
        wdata = {split ? need_q[15:0] : tsz_q, 1'b0};
        res_d.address_res = base_q + {42'd0, tg_q + 18'd1, 4'd0};
        state_d = S_DONE;
      end
      S_FWALK: begin
        if (g_q < {1'b0, target_q}) begin
          if (nxt < {1'b0, extent_q}) begin
            prev_d = g_q; prev_size_d = d_size; prev_free_d = d_free;
            has_prev_d = 1'b1; g_d = nxt; raddr = nxt[15:0];
          end else begin
            res_d.status = StBadFree; state_d = S_DONE;
          end
        end else if (g_q == {1'b0, target_q} && !d_free) begin
          merged_d = d_size;
          if (nxt < {1'b0, extent_q}) begin
            raddr = nxt[15:0]; state_d = S_FNEXT;
          end else begin
            state_d = S_FWR;
          end
        end else begin
          res_d.status = StBadFree; state_d = S_DONE;
        end
      end
      S_FNEXT: begin
        if (d_free) begin
          merged_d = merged_q + 16'd1 + d_size;
        end
        state_d = S_FWR;
      end
      S_FWR: begin
        we = 1'b1;
        if (has_prev_q && prev_free_q) begin
          waddr = prev_q[15:0]; wdata = {prev_size_q + 16'd1 + merged_q, 1'b1};
        end else begin
          waddr = g_q[15:0]; wdata = {merged_q, 1'b1};
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      base_q <= ResetHeapBase;
      extent_q <= InitExtent;
      init0_q <= 1'b1;
      rd0_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      extent_q <= extent_d;
      rd0_q <= (raddr == '0);
      if (we && waddr == '0) begin
        init0_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        base_q <= cfg_data_i;
      end
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    g_q <= g_d; need_q <= need_d; target_q <= target_d;
    last_q <= last_d; last_size_q <= last_size_d; last_free_q <= last_free_d;
    prev_q <= prev_d; prev_size_q <= prev_size_d; prev_free_q <= prev_free_d;
    has_prev_q <= has_prev_d; merged_q <= merged_d;
    tg_q <= tg_d; tsz_q <= tsz_d; res_q <= res_d;
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      out_q <= res_q;
    end
  end

endmodule
`default_nettype wire
